// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the list core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, switched off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the following clock cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ilir_pkg.sv =====
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ENTRY_W_DEF  = 16;

    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int PORT_E_W = 16;
    localparam int PORT_C_W = 7;
    localparam int EXT_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_PEEK   = 3'd4
    } t_op;

    typedef struct packed {
        logic clr;
        logic ins;
        logic rem;
        logic peek;
    } t_cell_ctl;

endpackage

// ===== rtl/ilir_cell.sv =====
`timescale 1ns / 1ps

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int CELL_POS = 0,
    parameter int IDX_W    = 6,
    parameter int ENTRY_W  = ENTRY_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_target,
    input  logic [ENTRY_W-1:0] i_entry,
    input  logic [ENTRY_W-1:0] i_prev,
    input  logic [ENTRY_W-1:0] i_next,
    output logic [ENTRY_W-1:0] o_entry,
    output logic [ENTRY_W-1:0] o_read
);

    logic [ENTRY_W-1:0] r_slot;
    logic [ENTRY_W-1:0] n_slot;
    logic               hit;
    logic               after;

    assign hit   = (i_target == IDX_W'(CELL_POS));
    assign after = (IDX_W'(CELL_POS) > i_target);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.clr) begin
            n_slot = '0;
        end else if (i_ctl.ins) begin
            if (hit) begin
                n_slot = i_entry;
            end else if (after) begin
                n_slot = i_prev;
            end
        end else if (i_ctl.rem) begin
            if (hit || after) begin
                n_slot = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_entry = r_slot;
    assign o_read  = (i_ctl.peek && hit) ? r_slot : '0;

endmodule

// ===== rtl/indexed_list_insert_remove_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                         Direction
// command   i_start, o_busy, i_op, i_position, i_entry_in  in
// result    o_done, o_ok, o_entry_out, o_count, o_empty_res out
//
// For every command all cells of the row shift or load in
// parallel, and the result is shown on o_done in the cycle after the transfer.
// A new command may be transferred in every cycle while o_busy is low.
// Reset is synchronous; o_busy is high for the first cycle after reset.
// The receiver cannot stall; each result is valid for exactly one cycle.

module indexed_list_insert_remove_core
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ENTRY_W  = ENTRY_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [POS_W-1:0]    i_position,
    input  logic [PORT_E_W-1:0] i_entry_in,
    output logic                o_done,
    output logic                o_ok,
    output logic [PORT_E_W-1:0] o_entry_out,
    output logic [PORT_C_W-1:0] o_count,
    output logic                o_empty_res
);

    `include "assert_macros.svh"

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                r_busy;
    logic                r_done;
    logic                r_ok;
    logic [PORT_E_W-1:0] r_entry_out;
    logic [PORT_C_W-1:0] r_count_out;
    logic                r_empty;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                accept;
    logic                ok;
    t_cell_ctl           ctl;
    logic [IDX_W-1:0]    target;
    logic [31:0]         idx32;
    logic [31:0]         cnt32;
    logic [EXT_W-1:0]    idx_ext;
    logic [EXT_W-1:0]    cnt_ext;
    logic [EXT_W-1:0]    ent_ext;
    logic [EXT_W-1:0]    rd_ext;
    logic [EXT_W-1:0]    ncnt_ext;
    logic [ENTRY_W-1:0]  wr_entry;
    logic [ENTRY_W-1:0]  rd_or;

    logic [ENTRY_W-1:0]  slot_q [CAPACITY];
    logic [ENTRY_W-1:0]  slot_rd [CAPACITY];

    assign accept   = i_start && !r_busy;
    assign idx32    = 32'(i_position);
    assign cnt32    = 32'(r_count);
    assign idx_ext  = EXT_W'(i_position);
    assign cnt_ext  = EXT_W'(r_count);
    assign ent_ext  = EXT_W'(i_entry_in);
    assign wr_entry = ent_ext[ENTRY_W-1:0];

    always_comb begin
        ctl     = '0;
        ok      = 1'b0;
        target  = idx_ext[IDX_W-1:0];
        n_count = r_count;
        if (accept) begin
            unique case (i_op)
                OP_CLEAR: begin
                    ctl.clr = 1'b1;
                    ok      = 1'b1;
                    n_count = '0;
                end
                OP_APPEND: begin
                    if (cnt32 < 32'(CAPACITY)) begin
                        ctl.ins = 1'b1;
                        ok      = 1'b1;
                        target  = cnt_ext[IDX_W-1:0];
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_INSERT: begin
                    if (idx32 <= cnt32 && idx32 < 32'(CAPACITY) &&
                        !(idx32 == cnt32 && cnt32 >= 32'(CAPACITY))) begin
                        ctl.ins = 1'b1;
                        ok      = 1'b1;
                        if (cnt32 < 32'(CAPACITY)) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                OP_REMOVE: begin
                    if (idx32 < cnt32) begin
                        ctl.rem = 1'b1;
                        ok      = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_PEEK: begin
                    if (idx32 < cnt32) begin
                        ctl.peek = 1'b1;
                        ok       = 1'b1;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_W-1:0] prev_in;
        logic [ENTRY_W-1:0] next_in;

        if (g == 0) begin : g_first
            assign prev_in = '0;
        end else begin : g_mid_prev
            assign prev_in = slot_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_in = '0;
        end else begin : g_mid_next
            assign next_in = slot_q[g+1];
        end

        ilir_cell #(
            .CELL_POS (g),
            .IDX_W    (IDX_W),
            .ENTRY_W  (ENTRY_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_target (target),
            .i_entry  (wr_entry),
            .i_prev   (prev_in),
            .i_next   (next_in),
            .o_entry  (slot_q[g]),
            .o_read   (slot_rd[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | slot_rd[k];
        end
    end

    assign rd_ext   = EXT_W'(rd_or);
    assign ncnt_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_done  <= accept;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok        <= ok;
        r_entry_out <= rd_ext[PORT_E_W-1:0];
        r_count_out <= ncnt_ext[PORT_C_W-1:0];
        r_empty     <= (n_count == '0);
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_entry_out = r_entry_out;
    assign o_count     = r_count_out;
    assign o_empty_res = r_empty;

    `ASSERT_IMPL(a_count_bound, 1'b1, 32'(r_count) <= 32'(CAPACITY),
        "List length exceeds capacity.")
    `ASSERT_NEXT(a_done_follows, accept, o_done,
        "An accepted command gave no result.")
    `ASSERT_NEXT(a_clear_empties, accept && i_op == OP_CLEAR,
        o_ok && o_empty_res && r_count == '0,
        "Clear did not leave the list empty.")
    `ASSERT_NEXT(a_no_spurious, !accept, !o_done,
        "Result shown without a command transfer.")

endmodule

// ===== sim/list_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the list and compares every result
// with the one predicted for the oldest outstanding command transfer.
module list_checker
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ENTRY_W  = ENTRY_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [POS_W-1:0]    i_position,
    input  logic [PORT_E_W-1:0] i_entry_in,
    input  logic                i_done,
    input  logic                i_ok,
    input  logic [PORT_E_W-1:0] i_entry_out,
    input  logic [PORT_C_W-1:0] i_count,
    input  logic                i_empty_res,
    output int                  o_fill_level,
    output int                  o_outstanding,
    output int                  o_mismatches
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [PORT_E_W-1:0] ENTRY_MASK = PORT_E_W'((65'd1 << ENTRY_W) - 65'd1);

    typedef struct packed {
        logic                ok;
        logic [PORT_E_W-1:0] entry;
        logic [PORT_C_W-1:0] count;
        logic                empty;
    } t_list_result;

    logic [PORT_E_W-1:0] held_entries [CAPACITY];
    int                  held_count;
    t_list_result        awaited_results [$];
    int                  reports_made;

    function automatic t_list_result run_command(input logic [OP_W-1:0] op, input int pos,
                                                 input logic [PORT_E_W-1:0] value);
        t_list_result res;
        int           new_count;
        res = '0;
        case (op)
            OP_CLEAR: begin
                foreach (held_entries[i]) held_entries[i] = '0;
                held_count = 0;
                res.ok     = 1'b1;
            end
            OP_APPEND: begin
                if (held_count < CAPACITY) begin
                    held_entries[held_count] = value & ENTRY_MASK;
                    held_count++;
                    res.ok = 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos <= held_count && pos < CAPACITY &&
                    !(pos == held_count && held_count >= CAPACITY)) begin
                    new_count = (held_count < CAPACITY) ? held_count + 1 : CAPACITY;
                    for (int i = new_count - 1; i > pos; i--)
                        held_entries[i] = held_entries[i-1];
                    held_entries[pos] = value & ENTRY_MASK;
                    held_count        = new_count;
                    res.ok            = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos < held_count) begin
                    for (int i = pos; i + 1 < held_count; i++)
                        held_entries[i] = held_entries[i+1];
                    held_entries[held_count-1] = '0;
                    held_count--;
                    res.ok = 1'b1;
                end
            end
            OP_PEEK: begin
                if (pos < held_count) begin
                    res.entry = held_entries[pos];
                    res.ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.count = PORT_C_W'(held_count);
        res.empty = (held_count == 0);
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input t_list_result want,
                                          input t_list_result seen);
        o_mismatches++;
        if (reports_made < REPORT_LIMIT) begin
            reports_made++;
            $display("%0t: %s: expected ok=%0b entry=%h count=%0d empty=%0b",
                     $realtime, what, want.ok, want.entry, want.count, want.empty);
            $display("%0t: %s: actual   ok=%0b entry=%h count=%0d empty=%0b",
                     $realtime, what, seen.ok, seen.entry, seen.count, seen.empty);
        end
    endfunction

    initial begin
        held_count    = 0;
        reports_made  = 0;
        o_fill_level  = 0;
        o_outstanding = 0;
        o_mismatches  = 0;
        foreach (held_entries[i]) held_entries[i] = '0;
    end

    always @(posedge i_clk) begin
        t_list_result seen;
        t_list_result want;
        if (!i_rst_n) begin
            foreach (held_entries[i]) held_entries[i] = '0;
            held_count = 0;
            awaited_results.delete();
        end else begin
            if (i_done) begin
                seen = '{i_ok, i_entry_out, i_count, i_empty_res};
                if (awaited_results.size() == 0) begin
                    note_mismatch("result without a command", '0, seen);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) note_mismatch("result mismatch", want, seen);
                end
            end
            if (i_start && !i_busy)
                awaited_results.push_back(run_command(i_op, int'(i_position), i_entry_in));
        end
        o_fill_level  = held_count;
        o_outstanding = awaited_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ilir_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int ITEM_TARGET   = 1800;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TOP_POSITION  = (1 << POS_W) - 1;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } t_stim_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [OP_W-1:0]     i_op;
    logic [POS_W-1:0]    i_position;
    logic [PORT_E_W-1:0] i_entry_in;
    logic                o_done;
    logic                o_ok;
    logic [PORT_E_W-1:0] o_entry_out;
    logic [PORT_C_W-1:0] o_count;
    logic                o_empty_res;

    int predicted_fill;
    int results_outstanding;
    int mismatch_count;
    int stall_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    indexed_list_insert_remove_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_entry_in  (i_entry_in),
        .o_done      (o_done),
        .o_ok        (o_ok),
        .o_entry_out (o_entry_out),
        .o_count     (o_count),
        .o_empty_res (o_empty_res)
    );

    list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_entry_in    (i_entry_in),
        .i_done        (o_done),
        .i_ok          (o_ok),
        .i_entry_out   (o_entry_out),
        .i_count       (o_count),
        .i_empty_res   (o_empty_res),
        .o_fill_level  (predicted_fill),
        .o_outstanding (results_outstanding),
        .o_mismatches  (mismatch_count)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Called just after a falling edge; returns at the falling edge after the transfer.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [PORT_E_W-1:0] value);
        i_start    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_entry_in <= value;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic pick_command(input t_stim_mode mode, output logic [OP_W-1:0] op,
                                output logic [POS_W-1:0] pos, output logic [PORT_E_W-1:0] value);
        int roll;
        int reach;
        roll = $urandom_range(0, 99);
        if (roll < 3 && mode == MODE_MIXED) begin
            op = (roll == 0) ? OP_CLEAR : OP_PEEK;
        end else if (roll < 5) begin
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end else begin
            roll = $urandom_range(0, 99);
            case (mode)
                MODE_GROW:   op = (roll < 48) ? OP_APPEND : (roll < 80) ? OP_INSERT :
                                  (roll < 90) ? OP_PEEK : OP_REMOVE;
                MODE_SHRINK: op = (roll < 13) ? OP_APPEND : (roll < 25) ? OP_INSERT :
                                  (roll < 45) ? OP_PEEK : OP_REMOVE;
                default:     op = (roll < 30) ? OP_APPEND : (roll < 55) ? OP_INSERT :
                                  (roll < 78) ? OP_PEEK : OP_REMOVE;
            endcase
        end
        reach = (op == OP_INSERT) ? predicted_fill : predicted_fill - 1;
        if (reach > TOP_POSITION) reach = TOP_POSITION;
        if (reach < 0 || $urandom_range(0, 4) == 0)
            pos = POS_W'($urandom_range(0, TOP_POSITION));
        else
            pos = POS_W'($urandom_range(0, reach));
        roll = $urandom_range(0, 9);
        value = (roll == 0) ? '0 : (roll == 1) ? '1 : PORT_E_W'($urandom_range(0, 16'hFFFF));
    endtask

    initial begin
        int               sent;
        int               burst;
        int               gap;
        int               episode_left;
        bit               paused;
        t_stim_mode       mode;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [PORT_E_W-1:0] value;

        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_op       = OP_CLEAR;
        i_position = '0;
        i_entry_in = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_command(OP_PEEK,   6'd0,  16'h0000);
        send_command(OP_REMOVE, 6'd0,  16'h0000);
        send_command(OP_INSERT, 6'd1,  16'h1234);
        send_command(OP_APPEND, 6'd0,  16'hFFFF);
        send_command(OP_APPEND, 6'd63, 16'h0000);
        send_command(OP_INSERT, 6'd0,  16'h8001);
        send_command(OP_INSERT, 6'd3,  16'h7FFE);
        send_command(OP_INSERT, 6'd63, 16'hAAAA);
        send_command(OP_PEEK,   6'd0,  16'hFFFF);
        send_command(OP_PEEK,   6'd3,  16'h0000);
        send_command(OP_PEEK,   6'd63, 16'h0000);
        send_command(OP_REMOVE, 6'd1,  16'h0000);
        send_command(OP_REMOVE, 6'd2,  16'h0000);
        send_command(OP_REMOVE, 6'd63, 16'h0000);
        send_command(OP_SPARE_FIRST, 6'd63, 16'hFFFF);
        send_command(OP_SPARE_MID,   6'd0,  16'h5555);
        send_command(OP_SPARE_LAST,  6'd1,  16'hFFFF);
        send_command(OP_PEEK,   6'd1,  16'h0000);
        send_command(OP_CLEAR,  6'd63, 16'hFFFF);
        send_command(OP_PEEK,   6'd0,  16'h0000);
        send_command(OP_APPEND, 6'd0,  16'h5A5A);
        send_command(OP_CLEAR,  6'd0,  16'h0000);

        sent         = 0;
        episode_left = 0;
        paused       = 1'b0;
        mode         = MODE_GROW;
        while (sent < ITEM_TARGET) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < ITEM_TARGET) begin
                if (episode_left == 0) begin
                    mode         = t_stim_mode'($urandom_range(MODE_GROW, MODE_MIXED));
                    episode_left = $urandom_range(40, 160);
                end
                pick_command(mode, op, pos, value);
                send_command(op, pos, value);
                sent++;
                episode_left--;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (!paused && sent >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                i_start <= 1'b0;
                do @(negedge i_clk); while (results_outstanding != 0);
            end else if (gap > 0 || sent >= ITEM_TARGET) begin
                i_start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end

        while (results_outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && results_outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/indexed_list_insert_remove_core.sv
sim/list_checker.sv
sim/testbench.sv
